// ===== sv/assert_macros.svh =====
// Assertion macros used by the RTL files.
// Every property is sampled on clk and disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that prop holds.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that cond is never true.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== sv/bai_pkg.sv =====
// Types and constants for the BAI index stream parser.
// Used by bai_core, bai_index_stream_parser and tb_top. No dependencies.
`timescale 1ns / 1ps

package bai_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_last;
  } in_beat_t;

  typedef struct packed {
    logic [3:0]  record_kind;
    logic [31:0] ref_number;
    logic [31:0] item_number;
    logic [63:0] value;
    logic [31:0] follow_count;
    logic [1:0]  error_code;
    logic        file_done;
  } rec_t;

  typedef enum logic [3:0] {
    PH_MAGIC,
    PH_NREF,
    PH_NBIN,
    PH_BIN,
    PH_NCHUNK,
    PH_CSTART,
    PH_CEND,
    PH_META,
    PH_NINTV,
    PH_INTV,
    PH_TRAILER,
    PH_EXTRA
  } phase_t;

  localparam logic [3:0] KIND_REFCOUNT = 4'd0;
  localparam logic [3:0] KIND_BIN      = 4'd1;
  localparam logic [3:0] KIND_CSTART   = 4'd2;
  localparam logic [3:0] KIND_CEND     = 4'd3;
  localparam logic [3:0] KIND_META     = 4'd4;
  localparam logic [3:0] KIND_INTERVAL = 4'd8;
  localparam logic [3:0] KIND_NOCOOR   = 4'd9;
  localparam logic [3:0] KIND_ERROR    = 4'd10;
  localparam logic [3:0] KIND_ENDONLY  = 4'd11;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_MAGIC = 2'd1;
  localparam logic [1:0] ERR_META  = 2'd2;
  localparam logic [1:0] ERR_TRUNC = 2'd3;

  localparam logic [31:0] MAGIC_WORD  = 32'h0149_4142;
  localparam logic [31:0] META_BIN    = 32'd37450;
  localparam logic [31:0] META_CHUNKS = 32'd2;

endpackage

// ===== sv/bai_index_stream_parser.sv =====
// Channel | dir | handshake          | payload
// in      | in  | in_valid/in_stall   | in_data  (bai_pkg::in_beat_t)
// out     | out | out_valid/out_stall | out_data (bai_pkg::rec_t)
// One byte per cycle while in_stall is low; an accepted beat yields at most one record.
// The record is registered in out_r, behind the decode in bai_core, or in the skid buffer.
// rst_n is synchronous; a beat flagged last also returns the parser to its reset state.
// A one-entry skid buffer catches one record while the output is held by out_stall;
// in_stall rises only when that skid entry is occupied.
// Top level of the BAI index stream parser. Depends on bai_pkg, bai_core, assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bai_index_stream_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  bai_pkg::in_beat_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output bai_pkg::rec_t     out_data
);
  import bai_pkg::*;

  logic beat;
  logic res_valid;
  rec_t res;
  logic out_valid_r;
  rec_t out_r;
  logic skid_valid_r;
  rec_t skid_r;
  logic out_free;
  logic out_held;
  logic out_err;
  logic out_coded;

  assign in_stall  = skid_valid_r;
  assign beat      = in_valid && !skid_valid_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_held  = out_valid_r && out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_err   = out_valid_r && (out_r.record_kind == KIND_ERROR);
  assign out_coded = out_valid_r && (out_r.error_code != ERR_NONE);

  bai_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .beat     (beat),
    .in_data  (in_data),
    .res_valid(res_valid),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_r <= skid_valid_r ? skid_r : res;
    end else if (res_valid) begin
      skid_r <= res;
    end
  end

  `ASSERT_CLK(a_skid_behind_out, skid_valid_r |-> out_valid_r, "skid beat without out beat")
  `ASSERT_CLK(a_skid_on_stall, $rose(skid_valid_r) |-> $past(out_held), "skid filled early")
  `ASSERT_NEVER(a_error_has_code, out_err && !out_coded, "error record without code")
  `ASSERT_NEVER(a_code_only_on_error, out_coded && !out_err, "error code on non-error record")

endmodule

// ===== sv/bai_core.sv =====
// Parser state and per-byte decode for the BAI index stream parser.
// Depends on bai_pkg. Result is combinational from the accepted beat.
`timescale 1ns / 1ps

module bai_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              beat,
  input  bai_pkg::in_beat_t in_data,
  output logic              res_valid,
  output bai_pkg::rec_t     res
);
  import bai_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [2:0]  byte_pos_r, byte_pos_nxt;
  logic [63:0] field_shift_r, field_shift_nxt;
  logic [31:0] refs_total_r, refs_total_nxt;
  logic [31:0] refs_done_r, refs_done_nxt;
  logic [31:0] bins_total_r, bins_total_nxt;
  logic [31:0] bins_done_r, bins_done_nxt;
  logic [31:0] chunks_total_r, chunks_total_nxt;
  logic [31:0] chunks_done_r, chunks_done_nxt;
  logic [31:0] intv_total_r, intv_total_nxt;
  logic [31:0] intv_done_r, intv_done_nxt;
  logic [31:0] current_bin_r, current_bin_nxt;
  logic [1:0]  meta_word_r, meta_word_nxt;
  logic        halted_r, halted_nxt;

  logic        active;
  logic        long_field;
  logic        field_done;
  logic [63:0] field_val;
  logic        err_hit;
  logic        have;
  logic [31:0] refs_inc, bins_inc, chunks_inc, intv_inc;

  assign active     = !halted_r && (phase_r != PH_EXTRA);
  assign long_field = (phase_r == PH_CSTART) || (phase_r == PH_CEND) ||
                      (phase_r == PH_META) || (phase_r == PH_INTV) ||
                      (phase_r == PH_TRAILER);
  assign field_done = long_field ? (byte_pos_r == 3'd7) : (byte_pos_r == 3'd3);
  assign field_val  = ((byte_pos_r == 3'd0) ? 64'd0 : field_shift_r) |
                      ({56'd0, in_data.data_byte} << {byte_pos_r, 3'b000});
  assign err_hit    = active && field_done &&
                      (((phase_r == PH_MAGIC) && (field_val[31:0] != MAGIC_WORD)) ||
                       ((phase_r == PH_NCHUNK) && (current_bin_r == META_BIN) &&
                        (field_val[31:0] != META_CHUNKS)));

  assign refs_inc   = refs_done_r + 32'd1;
  assign bins_inc   = bins_done_r + 32'd1;
  assign chunks_inc = chunks_done_r + 32'd1;
  assign intv_inc   = intv_done_r + 32'd1;

  // next state
  always_comb begin
    phase_nxt        = phase_r;
    byte_pos_nxt     = byte_pos_r;
    field_shift_nxt  = field_shift_r;
    refs_total_nxt   = refs_total_r;
    refs_done_nxt    = refs_done_r;
    bins_total_nxt   = bins_total_r;
    bins_done_nxt    = bins_done_r;
    chunks_total_nxt = chunks_total_r;
    chunks_done_nxt  = chunks_done_r;
    intv_total_nxt   = intv_total_r;
    intv_done_nxt    = intv_done_r;
    current_bin_nxt  = current_bin_r;
    meta_word_nxt    = meta_word_r;
    halted_nxt       = halted_r || err_hit;
    if (active) begin
      field_shift_nxt = field_val;
      byte_pos_nxt    = field_done ? 3'd0 : byte_pos_r + 3'd1;
      if (field_done) begin
        case (phase_r)
          PH_MAGIC: begin
            if (!err_hit) phase_nxt = PH_NREF;
          end
          PH_NREF: begin
            refs_total_nxt = field_val[31:0];
            refs_done_nxt  = 32'd0;
            phase_nxt      = (field_val[31:0] == 32'd0) ? PH_TRAILER : PH_NBIN;
          end
          PH_NBIN: begin
            bins_total_nxt = field_val[31:0];
            bins_done_nxt  = 32'd0;
            phase_nxt      = (field_val[31:0] == 32'd0) ? PH_NINTV : PH_BIN;
          end
          PH_BIN: begin
            current_bin_nxt = field_val[31:0];
            phase_nxt       = PH_NCHUNK;
          end
          PH_NCHUNK: begin
            chunks_total_nxt = field_val[31:0];
            chunks_done_nxt  = 32'd0;
            if (current_bin_r == META_BIN) begin
              if (!err_hit) begin
                meta_word_nxt = 2'd0;
                phase_nxt     = PH_META;
              end
            end else if (field_val[31:0] == 32'd0) begin
              bins_done_nxt = bins_inc;
              phase_nxt     = (bins_inc == bins_total_r) ? PH_NINTV : PH_BIN;
            end else begin
              phase_nxt = PH_CSTART;
            end
          end
          PH_CSTART: begin
            phase_nxt = PH_CEND;
          end
          PH_CEND: begin
            chunks_done_nxt = chunks_inc;
            if (chunks_inc == chunks_total_r) begin
              bins_done_nxt = bins_inc;
              phase_nxt     = (bins_inc == bins_total_r) ? PH_NINTV : PH_BIN;
            end else begin
              phase_nxt = PH_CSTART;
            end
          end
          PH_META: begin
            if (meta_word_r == 2'd3) begin
              meta_word_nxt = 2'd0;
              bins_done_nxt = bins_inc;
              phase_nxt     = (bins_inc == bins_total_r) ? PH_NINTV : PH_BIN;
            end else begin
              meta_word_nxt = meta_word_r + 2'd1;
            end
          end
          PH_NINTV: begin
            intv_total_nxt = field_val[31:0];
            intv_done_nxt  = 32'd0;
            if (field_val[31:0] == 32'd0) begin
              refs_done_nxt = refs_inc;
              phase_nxt     = (refs_inc == refs_total_r) ? PH_TRAILER : PH_NBIN;
            end else begin
              phase_nxt = PH_INTV;
            end
          end
          PH_INTV: begin
            intv_done_nxt = intv_inc;
            if (intv_inc == intv_total_r) begin
              refs_done_nxt = refs_inc;
              phase_nxt     = (refs_inc == refs_total_r) ? PH_TRAILER : PH_NBIN;
            end
          end
          PH_TRAILER: begin
            if (!in_data.is_last) phase_nxt = PH_EXTRA;
          end
          default: ;
        endcase
      end
    end
  end

  // result
  always_comb begin
    res  = '0;
    have = 1'b0;
    if (!halted_r) begin
      if (active && field_done) begin
        case (phase_r)
          PH_MAGIC: begin
            if (err_hit) begin
              res.record_kind = KIND_ERROR;
              res.error_code  = ERR_MAGIC;
              have            = 1'b1;
            end
          end
          PH_NREF: begin
            res.record_kind = KIND_REFCOUNT;
            res.value       = field_val;
            have            = 1'b1;
          end
          PH_NCHUNK: begin
            if (current_bin_r == META_BIN) begin
              if (err_hit) begin
                res.record_kind = KIND_ERROR;
                res.error_code  = ERR_META;
                have            = 1'b1;
              end
            end else begin
              res.record_kind  = KIND_BIN;
              res.ref_number   = refs_done_r;
              res.item_number  = bins_done_r;
              res.value        = {32'd0, current_bin_r};
              res.follow_count = field_val[31:0];
              have             = 1'b1;
            end
          end
          PH_CSTART, PH_CEND: begin
            res.record_kind = (phase_r == PH_CSTART) ? KIND_CSTART : KIND_CEND;
            res.ref_number  = refs_done_r;
            res.item_number = chunks_done_r;
            res.value       = field_val;
            have            = 1'b1;
          end
          PH_META: begin
            res.record_kind = KIND_META + {2'b00, meta_word_r};
            res.ref_number  = refs_done_r;
            res.item_number = bins_done_r;
            res.value       = field_val;
            have            = 1'b1;
          end
          PH_INTV: begin
            res.record_kind = KIND_INTERVAL;
            res.ref_number  = refs_done_r;
            res.item_number = intv_done_r;
            res.value       = field_val;
            have            = 1'b1;
          end
          PH_TRAILER: begin
            if (in_data.is_last) begin
              res.record_kind = KIND_NOCOOR;
              res.value       = field_val;
              have            = 1'b1;
            end
          end
          default: ;
        endcase
      end
      if (in_data.is_last) begin
        if (!err_hit) begin
          if ((phase_nxt == PH_TRAILER) || (phase_nxt == PH_EXTRA)) begin
            if (!have) res.record_kind = KIND_ENDONLY;
          end else begin
            res             = '0;
            res.record_kind = KIND_ERROR;
            res.error_code  = ERR_TRUNC;
          end
        end
        res.file_done = 1'b1;
        have          = 1'b1;
      end
    end
  end

  assign res_valid = beat && have;

  always_ff @(posedge clk) begin
    if (!rst_n || (beat && in_data.is_last)) begin
      phase_r        <= PH_MAGIC;
      byte_pos_r     <= 3'd0;
      field_shift_r  <= 64'd0;
      refs_total_r   <= 32'd0;
      refs_done_r    <= 32'd0;
      bins_total_r   <= 32'd0;
      bins_done_r    <= 32'd0;
      chunks_total_r <= 32'd0;
      chunks_done_r  <= 32'd0;
      intv_total_r   <= 32'd0;
      intv_done_r    <= 32'd0;
      current_bin_r  <= 32'd0;
      meta_word_r    <= 2'd0;
      halted_r       <= 1'b0;
    end else if (beat) begin
      phase_r        <= phase_nxt;
      byte_pos_r     <= byte_pos_nxt;
      field_shift_r  <= field_shift_nxt;
      refs_total_r   <= refs_total_nxt;
      refs_done_r    <= refs_done_nxt;
      bins_total_r   <= bins_total_nxt;
      bins_done_r    <= bins_done_nxt;
      chunks_total_r <= chunks_total_nxt;
      chunks_done_r  <= chunks_done_nxt;
      intv_total_r   <= intv_total_nxt;
      intv_done_r    <= intv_done_nxt;
      current_bin_r  <= current_bin_nxt;
      meta_word_r    <= meta_word_nxt;
      halted_r       <= halted_nxt;
    end
  end

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for bai_index_stream_parser: directed and random BAI files, byte by byte.
// Predicts records with its own parser model and checks them in order; needs bai_pkg
// and the parser RTL.
`timescale 1ns / 1ps

module tb_top;
  import bai_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int BYTE_TARGET = 1450;

  typedef struct {
    in_beat_t    beat;
    int unsigned gap;
    bit          drain;
  } byte_slot_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  in_beat_t in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  rec_t     out_data;

  bai_index_stream_parser dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  byte_slot_t  pending_beats[$];
  rec_t        expected_recs[$];
  logic [7:0]  file_bytes[$];
  rec_t        exp_rec;
  int          fail_count = 0;
  int          cycle_count = 0;
  int          queued_total = 0;
  int          files_made = 0;
  int          recs_checked = 0;
  int          errors_seen = 0;
  int          unplaced_seen = 0;
  int          recv_count = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;

  // parser model state
  phase_t      ph;
  logic [2:0]  pos;
  logic [63:0] shreg;
  logic [31:0] n_refs, refs_seen, n_bins, bins_seen;
  logic [31:0] n_chunks, chunks_seen, n_ivals, ivals_seen;
  logic [31:0] bin_id;
  logic [1:0]  meta_idx;
  bit          stopped;

  function void clear_parse_state();
    ph = PH_MAGIC;
    pos = '0;
    shreg = '0;
    n_refs = '0;
    refs_seen = '0;
    n_bins = '0;
    bins_seen = '0;
    n_chunks = '0;
    chunks_seen = '0;
    n_ivals = '0;
    ivals_seen = '0;
    bin_id = '0;
    meta_idx = '0;
    stopped = 0;
  endfunction

  function automatic rec_t make_rec(logic [3:0] kind, logic [31:0] rn, logic [31:0] item,
                                    logic [63:0] val, logic [31:0] fc, logic [1:0] ec);
    rec_t r;
    r.record_kind = kind;
    r.ref_number = rn;
    r.item_number = item;
    r.value = val;
    r.follow_count = fc;
    r.error_code = ec;
    r.file_done = 1'b0;
    return r;
  endfunction

  function void close_ref();
    refs_seen++;
    if (refs_seen == n_refs) ph = PH_TRAILER;
    else ph = PH_NBIN;
  endfunction

  function void close_bin();
    bins_seen++;
    if (bins_seen == n_bins) ph = PH_NINTV;
    else ph = PH_BIN;
  endfunction

  function void decode_byte(in_beat_t beat);
    rec_t        r;
    bit          have;
    bit          err;
    int          len;
    logic [63:0] v;
    have = 0;
    err = 0;
    r = '0;
    if (stopped) begin
      if (beat.is_last) clear_parse_state();
      return;
    end
    if (ph <= PH_TRAILER) begin
      if (ph == PH_CSTART || ph == PH_CEND || ph == PH_META || ph == PH_INTV ||
          ph == PH_TRAILER) len = 8;
      else len = 4;
      if (pos == 0) shreg = '0;
      shreg |= 64'(beat.data_byte) << (8 * pos);
      if (int'(pos) + 1 < len) begin
        pos++;
      end else begin
        pos = '0;
        v = shreg;
        case (ph)
          PH_MAGIC: begin
            if (v[31:0] != MAGIC_WORD) begin
              r = make_rec(KIND_ERROR, 0, 0, 0, 0, ERR_MAGIC);
              have = 1;
              err = 1;
              stopped = 1;
            end else begin
              ph = PH_NREF;
            end
          end
          PH_NREF: begin
            n_refs = v[31:0];
            refs_seen = '0;
            r = make_rec(KIND_REFCOUNT, 0, 0, v, 0, ERR_NONE);
            have = 1;
            if (n_refs == 0) ph = PH_TRAILER;
            else ph = PH_NBIN;
          end
          PH_NBIN: begin
            n_bins = v[31:0];
            bins_seen = '0;
            if (n_bins == 0) ph = PH_NINTV;
            else ph = PH_BIN;
          end
          PH_BIN: begin
            bin_id = v[31:0];
            ph = PH_NCHUNK;
          end
          PH_NCHUNK: begin
            n_chunks = v[31:0];
            chunks_seen = '0;
            if (bin_id == META_BIN) begin
              if (n_chunks != META_CHUNKS) begin
                r = make_rec(KIND_ERROR, 0, 0, 0, 0, ERR_META);
                have = 1;
                err = 1;
                stopped = 1;
              end else begin
                meta_idx = '0;
                ph = PH_META;
              end
            end else begin
              r = make_rec(KIND_BIN, refs_seen, bins_seen, 64'(bin_id), n_chunks, ERR_NONE);
              have = 1;
              if (n_chunks == 0) close_bin();
              else ph = PH_CSTART;
            end
          end
          PH_CSTART: begin
            r = make_rec(KIND_CSTART, refs_seen, chunks_seen, v, 0, ERR_NONE);
            have = 1;
            ph = PH_CEND;
          end
          PH_CEND: begin
            r = make_rec(KIND_CEND, refs_seen, chunks_seen, v, 0, ERR_NONE);
            have = 1;
            chunks_seen++;
            if (chunks_seen == n_chunks) close_bin();
            else ph = PH_CSTART;
          end
          PH_META: begin
            r = make_rec(4'(KIND_META + meta_idx), refs_seen, bins_seen, v, 0, ERR_NONE);
            have = 1;
            if (meta_idx == 2'd3) begin
              meta_idx = '0;
              close_bin();
            end else begin
              meta_idx++;
            end
          end
          PH_NINTV: begin
            n_ivals = v[31:0];
            ivals_seen = '0;
            if (n_ivals == 0) close_ref();
            else ph = PH_INTV;
          end
          PH_INTV: begin
            r = make_rec(KIND_INTERVAL, refs_seen, ivals_seen, v, 0, ERR_NONE);
            have = 1;
            ivals_seen++;
            if (ivals_seen == n_ivals) close_ref();
          end
          default: begin
            if (beat.is_last) begin
              r = make_rec(KIND_NOCOOR, 0, 0, v, 0, ERR_NONE);
              have = 1;
            end else begin
              ph = PH_EXTRA;
            end
          end
        endcase
      end
    end
    if (beat.is_last) begin
      if (!err) begin
        if (ph == PH_TRAILER || ph >= PH_EXTRA) begin
          if (!have) begin
            r = make_rec(KIND_ENDONLY, 0, 0, 0, 0, ERR_NONE);
            have = 1;
          end
        end else begin
          r = make_rec(KIND_ERROR, 0, 0, 0, 0, ERR_TRUNC);
          have = 1;
        end
      end
      r.file_done = 1'b1;
      clear_parse_state();
    end
    if (have) expected_recs.insert(expected_recs.size(), r);
  endfunction

  // stimulus construction
  function void add_byte(logic [7:0] b);
    file_bytes.insert(file_bytes.size(), b);
  endfunction

  function void add_field(logic [63:0] v, int nbytes);
    for (int i = 0; i < nbytes; i++) add_byte(v[8*i +: 8]);
  endfunction

  function automatic logic [63:0] rand_word(int nbytes);
    logic [63:0] w;
    case ($urandom_range(0, 5))
      0: w = '0;
      1: w = '1;
      default: w = {$urandom, $urandom};
    endcase
    if (nbytes == 4) w[63:32] = '0;
    return w;
  endfunction

  function void build_file();
    int nrefs, nbins, nch, nint, tlen, cut;
    logic [31:0] bin_num;
    file_bytes.delete();
    if ($urandom_range(0, 15) == 0) begin
      repeat ($urandom_range(1, 10)) add_byte(8'($urandom));
      return;
    end
    add_field(64'(MAGIC_WORD), 4);
    if ($urandom_range(0, 11) == 0)
      file_bytes[$urandom_range(0, 3)] ^= 8'($urandom_range(1, 255));
    nrefs = $urandom_range(0, 2);
    if ($urandom_range(0, 19) == 0) add_field(rand_word(4), 4);
    else add_field(64'(nrefs), 4);
    for (int r = 0; r < nrefs; r++) begin
      nbins = $urandom_range(0, 2);
      add_field(64'(nbins), 4);
      for (int b = 0; b < nbins; b++) begin
        if ($urandom_range(0, 3) == 0) begin
          add_field(64'(META_BIN), 4);
          if ($urandom_range(0, 4) == 0) add_field(64'($urandom_range(0, 1) ? 3 : 1), 4);
          else add_field(64'(META_CHUNKS), 4);
          repeat (4) add_field(rand_word(8), 8);
        end else begin
          bin_num = 32'(rand_word(4));
          if (bin_num == META_BIN) bin_num = 32'd0;
          nch = $urandom_range(0, 2);
          add_field(64'(bin_num), 4);
          add_field(64'(nch), 4);
          repeat (2 * nch) add_field(rand_word(8), 8);
        end
      end
      nint = $urandom_range(0, 2);
      add_field(64'(nint), 4);
      repeat (nint) add_field(rand_word(8), 8);
    end
    tlen = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 12) : 8;
    repeat (tlen) add_byte(8'($urandom));
    if ($urandom_range(0, 4) == 0 && file_bytes.size() > 1) begin
      cut = $urandom_range(1, file_bytes.size() - 1);
      while (file_bytes.size() > cut) void'(file_bytes.pop_back());
    end
  endfunction

  function void queue_file(bit drain_first);
    byte_slot_t slot;
    for (int i = 0; i < file_bytes.size(); i++) begin
      slot.beat.data_byte = file_bytes[i];
      slot.beat.is_last = (i == file_bytes.size() - 1);
      slot.gap = (((queued_total / 200) % 4) == 3) ? 0 : $urandom_range(0, 9);
      slot.drain = drain_first && (i == 0);
      pending_beats.insert(pending_beats.size(), slot);
      queued_total++;
    end
  endfunction

  initial begin
    forever #5 clk = ~clk;
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (pending_beats.size() == 0) begin
        in_valid <= 1'b0;
      end else if (pending_beats[0].gap != 0) begin
        pending_beats[0].gap--;
        in_valid <= 1'b0;
      end else if (pending_beats[0].drain && (in_valid || expected_recs.size() != 0)) begin
        in_valid <= 1'b0;
      end else begin
        in_data <= pending_beats[0].beat;
        in_valid <= 1'b1;
        void'(pending_beats.pop_front());
      end
    end
  end

  // receiver: per-record stall, calm stretches, two long hold-offs
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        recv_count++;
        stall_left = (((recv_count / 50) % 4) == 1) ? 0 : $urandom_range(0, 9);
        if (recv_count == 40 || recv_count == 180) hold_left = 80;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left != 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endfunction

  // monitor: predict on each accepted input beat, then check the output beat
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) decode_byte(in_data);
      if (out_valid && !out_stall) begin
        if (expected_recs.size() == 0) begin
          $error("record_kind: expected none, got %0d", out_data.record_kind);
          fail_count++;
        end else begin
          exp_rec = expected_recs.pop_front();
          check_field("record_kind", 64'(exp_rec.record_kind), 64'(out_data.record_kind));
          check_field("ref_number", 64'(exp_rec.ref_number), 64'(out_data.ref_number));
          check_field("item_number", 64'(exp_rec.item_number), 64'(out_data.item_number));
          check_field("value", exp_rec.value, out_data.value);
          check_field("follow_count", 64'(exp_rec.follow_count), 64'(out_data.follow_count));
          check_field("error_code", 64'(exp_rec.error_code), 64'(out_data.error_code));
          check_field("file_done", 64'(exp_rec.file_done), 64'(out_data.file_done));
          recs_checked++;
          if (exp_rec.record_kind == KIND_ERROR) errors_seen++;
          if (exp_rec.record_kind == KIND_NOCOOR) unplaced_seen++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    clear_parse_state();
    // lone last byte, bad magic with halted tail, empty index with all-ones trailer
    file_bytes = '{8'h00};
    queue_file(0);
    file_bytes = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00};
    queue_file(0);
    file_bytes.delete();
    add_field(64'(MAGIC_WORD), 4);
    add_field(64'd0, 4);
    add_field('1, 8);
    queue_file(0);
    files_made = 3;
    while (queued_total < BYTE_TARGET) begin
      build_file();
      queue_file(files_made % 5 == 3);
      files_made++;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_beats.size() != 0 || in_valid || expected_recs.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Run covered %0d files, %0d bytes, %0d records checked", files_made,
             queued_total, recs_checked);
    $display("(%0d error records, %0d unplaced counts).", errors_seen, unplaced_seen);
    if (fail_count == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== bai_index_stream_parser.f =====
+incdir+sv
sv/bai_pkg.sv
sv/bai_core.sv
sv/bai_index_stream_parser.sv
tb/sv/tb_top.sv
